// ===== hdl/vector_to_pitch_yaw_degrees_core_defines.svh =====
// assertion macros used by the core rtl file
`ifndef VECTOR_TO_PITCH_YAW_DEGREES_CORE_DEFINES_SVH
`define VECTOR_TO_PITCH_YAW_DEGREES_CORE_DEFINES_SVH

// checked while out of reset
`define V2PYD_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) \
      else $error(msg);

// checked through reset as well
`define V2PYD_ASSERT_RST(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) prop) else $error(msg);

`endif

// ===== hdl/v2pyd_pkg.sv =====
`default_nettype none

package v2pyd_pkg;

   localparam int COORD_BITS   = 24;
   localparam int CORDIC_STEPS = 24;
   localparam int ROT_STAGES   = 2 * CORDIC_STEPS;
   localparam int FRAC_BITS    = 27;
   localparam int ANG_SHIFT    = 32;
   localparam int DEG_W        = 10;
   localparam int ANG_W        = DEG_W + ANG_SHIFT;
   localparam int CW           = COORD_BITS + FRAC_BITS + 5;
   localparam int KW           = FRAC_BITS + 1;
   localparam int SQ_W         = 2 * COORD_BITS;
   localparam int OUT_W        = 9;
   localparam int STEP_W       = $clog2(CORDIC_STEPS);

   localparam logic [63:0] DEG_PER_RAD_Q26 = 64'd3845054675;

   localparam logic [OUT_W-1:0] DEG_0   = 9'd0;
   localparam logic [OUT_W-1:0] DEG_45  = 9'd45;
   localparam logic [OUT_W-1:0] DEG_90  = 9'd90;
   localparam logic [OUT_W-1:0] DEG_135 = 9'd135;
   localparam logic [OUT_W-1:0] DEG_180 = 9'd180;
   localparam logic [OUT_W-1:0] DEG_225 = 9'd225;
   localparam logic [OUT_W-1:0] DEG_270 = 9'd270;
   localparam logic [OUT_W-1:0] DEG_315 = 9'd315;
   localparam logic [DEG_W-1:0] DEG_FULL = 10'd360;

   localparam logic signed [ANG_W-1:0] ANG_HALF_TURN = ANG_W'(64'd180 << ANG_SHIFT);
   localparam logic signed [ANG_W-1:0] ANG_EIGHTH    = ANG_W'(64'd45 << ANG_SHIFT);

   typedef struct packed {
      logic signed [CW-1:0] hold;
      logic                 yaw_fix;
      logic [OUT_W-1:0]     yaw_val;
      logic                 pitch_fix;
      logic [OUT_W-1:0]     pitch_val;
   } side_type;

   typedef struct packed {
      logic signed [CW-1:0]    x;
      logic signed [CW-1:0]    y;
      logic signed [ANG_W-1:0] ang;
      side_type                side;
   } rot_type;

   // shift-subtract division, elaboration only
   function automatic logic [63:0] udiv64(input logic [63:0] num, input logic [63:0] den);
      logic [64:0] rem;
      logic [63:0] quo;
      int          b;
      rem = '0;
      quo = '0;
      for (b = 63; b >= 0; b--) begin
         rem = {rem[63:0], num[b]};
         if (rem >= {1'b0, den}) begin
            rem    = rem - {1'b0, den};
            quo[b] = 1'b1;
         end
      end
      return quo;
   endfunction

   // atan(2^-idx) in units of 2^-32 degree, from the power series in Q62 radians
   function automatic logic signed [ANG_W-1:0] atan_entry(input int idx);
      logic [63:0] acc;
      logic [63:0] term;
      logic [63:0] prod;
      int          p;
      int          k;
      logic        done;
      acc  = '0;
      done = 1'b0;
      if (idx == 0) begin
         return ANG_EIGHTH;
      end
      for (k = 0; k < 32; k++) begin
         p = (2 * k + 1) * idx;
         if (p > 62) begin
            done = 1'b1;
         end
         if (!done) begin
            term = udiv64(64'd1 << (62 - p), 64'(2 * k + 1));
            if (k[0]) begin
               acc = acc - term;
            end else begin
               acc = acc + term;
            end
         end
      end
      prod = (acc >> 30) * DEG_PER_RAD_Q26;
      return ANG_W'(prod >> 26);
   endfunction

   // cordic gain in Q(FRAC_BITS), square root rounded down
   function automatic logic [KW-1:0] gain_q();
      logic [63:0] k2;
      logic [63:0] v;
      logic [63:0] r;
      logic [63:0] bit_w;
      int          i;
      k2 = 64'd1 << 61;
      for (i = 1; i < CORDIC_STEPS; i++) begin
         k2 = k2 + (k2 >> (2 * i));
      end
      v     = k2 >> (60 - 2 * FRAC_BITS);
      r     = '0;
      bit_w = 64'd1 << 62;
      for (i = 0; i < 32; i++) begin
         if (bit_w > v) begin
            bit_w = bit_w >> 2;
         end
      end
      for (i = 0; i < 32; i++) begin
         if (bit_w != 64'd0) begin
            if (v >= r + bit_w) begin
               v = v - (r + bit_w);
               r = (r >> 1) + bit_w;
            end else begin
               r = r >> 1;
            end
            bit_w = bit_w >> 2;
         end
      end
      return KW'(r);
   endfunction

   localparam logic [KW-1:0] GAIN_Q = gain_q();

endpackage

`default_nettype wire

// ===== hdl/v2pyd_chan_ifs.sv =====
`default_nettype none

interface v2pyd_req_if import v2pyd_pkg::*; ();
   logic                         valid;
   logic                         ready;
   logic signed [COORD_BITS-1:0] vec_x;
   logic signed [COORD_BITS-1:0] vec_y;
   logic signed [COORD_BITS-1:0] vec_z;

   modport source (output valid, output vec_x, output vec_y, output vec_z, input ready);
   modport sink (input valid, input vec_x, input vec_y, input vec_z, output ready);
endinterface

interface v2pyd_rsp_if import v2pyd_pkg::*; ();
   logic             valid;
   logic             ready;
   logic [OUT_W-1:0] pitch_deg;
   logic [OUT_W-1:0] yaw_deg;

   modport source (output valid, output pitch_deg, output yaw_deg, input ready);
   modport sink (input valid, input pitch_deg, input yaw_deg, output ready);
endinterface

`default_nettype wire

// ===== hdl/vector_to_pitch_yaw_degrees_core.sv =====
// channel  dir  handshake    payload
// req_ch   in   valid/ready  vec_x, vec_y, vec_z (signed, COORD_BITS each)
// rsp_ch   out  valid/ready  pitch_deg, yaw_deg (0..359)
//
// one item per cycle sustained while rsp_ch.ready stays high; the registers in order:
// two input stages, one stage per micro-rotation over both passes, one output register
// each stage moves when the stage after it is empty or moving, so bubbles fill under a stall
// reset is synchronous and clears the valid bit of every stage; payload is not reset
`default_nettype none
`include "vector_to_pitch_yaw_degrees_core_defines.svh"

module vector_to_pitch_yaw_degrees_core import v2pyd_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   v2pyd_req_if.sink   req_ch,
   v2pyd_rsp_if.source rsp_ch
);

   rot_type           stg_data  [ROT_STAGES+1];
   logic [ROT_STAGES:0] stg_valid;
   logic [ROT_STAGES:0] stg_ready;

   v2pyd_prep u_prep (
      .clock     (clock),
      .reset     (reset),
      .req_ch    (req_ch),
      .out_valid (stg_valid[0]),
      .out_ready (stg_ready[0]),
      .out_data  (stg_data[0])
   );

   for (genvar g = 0; g < ROT_STAGES; g++) begin : g_rot
      localparam int Idx = (g < CORDIC_STEPS) ? g : g - CORDIC_STEPS;
      localparam logic signed [ANG_W-1:0] AtanVal = atan_entry(Idx);

      rot_type rot_in;

      if (g == CORDIC_STEPS) begin : g_swap
         // second pass: horizontal length against gained z, yaw angle parked
         always_comb begin
            rot_in           = stg_data[g];
            rot_in.y         = stg_data[g].side.hold;
            rot_in.ang       = '0;
            rot_in.side.hold = CW'(stg_data[g].ang);
         end
      end else begin : g_pass
         assign rot_in = stg_data[g];
      end

      v2pyd_rot_stage u_stage (
         .clock     (clock),
         .reset     (reset),
         .in_valid  (stg_valid[g]),
         .in_ready  (stg_ready[g]),
         .in_data   (rot_in),
         .shift_amt (STEP_W'(Idx)),
         .atan_val  (AtanVal),
         .out_valid (stg_valid[g+1]),
         .out_ready (stg_ready[g+1]),
         .out_data  (stg_data[g+1])
      );
   end

   v2pyd_post u_post (
      .clock    (clock),
      .reset    (reset),
      .in_valid (stg_valid[ROT_STAGES]),
      .in_ready (stg_ready[ROT_STAGES]),
      .in_data  (stg_data[ROT_STAGES]),
      .rsp_ch   (rsp_ch)
   );

   `V2PYD_ASSERT_RST(a_rst_clears_rsp, reset |=> !rsp_ch.valid, "result valid right after reset")
   `V2PYD_ASSERT(a_deg_range, rsp_ch.valid |-> ({1'b0, rsp_ch.pitch_deg} < DEG_FULL) && ({1'b0, rsp_ch.yaw_deg} < DEG_FULL), "angle out of range")
   `V2PYD_ASSERT(a_len_nonneg, stg_valid[ROT_STAGES] |-> !stg_data[ROT_STAGES].x[CW-1], "vector length went negative")
   `V2PYD_ASSERT(a_ready_chain, rsp_ch.ready |-> req_ch.ready, "input blocked while output drains")

endmodule

`default_nettype wire

// ===== hdl/v2pyd_rot_stage.sv =====
`default_nettype none

module v2pyd_rot_stage import v2pyd_pkg::*; (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    in_valid,
   output logic                    in_ready,
   input  rot_type                 in_data,
   input  logic [STEP_W-1:0]       shift_amt,
   input  logic signed [ANG_W-1:0] atan_val,
   output logic                    out_valid,
   input  logic                    out_ready,
   output rot_type                 out_data
);

   logic signed [CW-1:0] dx;
   logic signed [CW-1:0] dy;
   rot_type              data_in;
   rot_type              data_ff;
   logic                 valid_ff;

   assign dx = in_data.y >>> shift_amt;
   assign dy = in_data.x >>> shift_amt;

   // turn toward the x axis, accumulate the angle taken
   always_comb begin
      data_in = in_data;
      if (!in_data.y[CW-1]) begin
         data_in.x   = in_data.x + dx;
         data_in.y   = in_data.y - dy;
         data_in.ang = in_data.ang + atan_val;
      end else begin
         data_in.x   = in_data.x - dx;
         data_in.y   = in_data.y + dy;
         data_in.ang = in_data.ang - atan_val;
      end
   end

   assign in_ready = !valid_ff || out_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         data_ff <= data_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

endmodule

`default_nettype wire

// ===== hdl/v2pyd_prep.sv =====
`default_nettype none

module v2pyd_prep import v2pyd_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   v2pyd_req_if.sink   req_ch,
   output logic        out_valid,
   input  logic        out_ready,
   output rot_type     out_data
);

   typedef struct packed {
      logic             zero_h;
      logic             z_pos;
      logic             z_zero;
      logic             yaw_fix;
      logic [OUT_W-1:0] yaw_val;
   } pflag_type;

   // stage 1: fold into the right half plane, scale, square, apply gain to z, flag exact yaw cases
   logic [COORD_BITS-1:0]     ax;
   logic [COORD_BITS-1:0]     ay;
   logic [COORD_BITS-1:0]     az;
   logic                      x_neg;
   logic                      y_neg;
   logic                      x_zero;
   logic                      y_zero;
   logic signed [CW-1:0]      x_scl;
   logic signed [CW-1:0]      y_scl;
   logic signed [COORD_BITS+KW:0] zy_prod;

   logic                      s1_valid_ff;
   logic signed [CW-1:0]      s1_cx_in;
   logic signed [CW-1:0]      s1_cx_ff;
   logic signed [CW-1:0]      s1_cy_in;
   logic signed [CW-1:0]      s1_cy_ff;
   logic signed [ANG_W-1:0]   s1_ang_in;
   logic signed [ANG_W-1:0]   s1_ang_ff;
   logic signed [CW-1:0]      s1_zy_ff;
   logic [SQ_W-1:0]           s1_sqx_in;
   logic [SQ_W-1:0]           s1_sqx_ff;
   logic [SQ_W-1:0]           s1_sqy_in;
   logic [SQ_W-1:0]           s1_sqy_ff;
   logic [SQ_W-1:0]           s1_sqz_in;
   logic [SQ_W-1:0]           s1_sqz_ff;
   pflag_type                 s1_flag_in;
   pflag_type                 s1_flag_ff;

   logic                      s2_ready;
   logic                      s2_valid_ff;
   logic [SQ_W:0]             sq_sum;
   logic                      diag_hit;
   rot_type                   s2_data_in;
   rot_type                   s2_data_ff;

   assign x_neg  = req_ch.vec_x[COORD_BITS-1];
   assign y_neg  = req_ch.vec_y[COORD_BITS-1];
   assign x_zero = (req_ch.vec_x == '0);
   assign y_zero = (req_ch.vec_y == '0);

   assign ax = x_neg ? COORD_BITS'(-req_ch.vec_x) : COORD_BITS'(req_ch.vec_x);
   assign ay = y_neg ? COORD_BITS'(-req_ch.vec_y) : COORD_BITS'(req_ch.vec_y);
   assign az = req_ch.vec_z[COORD_BITS-1] ? COORD_BITS'(-req_ch.vec_z)
                                          : COORD_BITS'(req_ch.vec_z);

   assign x_scl = CW'(req_ch.vec_x) <<< FRAC_BITS;
   assign y_scl = CW'(req_ch.vec_y) <<< FRAC_BITS;

   assign zy_prod = req_ch.vec_z * $signed({1'b0, GAIN_Q});

   assign s1_sqx_in = ax * ax;
   assign s1_sqy_in = ay * ay;
   assign s1_sqz_in = az * az;

   always_comb begin
      s1_cx_in  = x_scl;
      s1_cy_in  = y_scl;
      s1_ang_in = '0;
      if (x_neg) begin
         s1_cx_in  = -x_scl;
         s1_cy_in  = -y_scl;
         s1_ang_in = y_neg ? -ANG_HALF_TURN : ANG_HALF_TURN;
      end
   end

   always_comb begin
      s1_flag_in.zero_h  = x_zero && y_zero;
      s1_flag_in.z_zero  = (req_ch.vec_z == '0);
      s1_flag_in.z_pos   = !req_ch.vec_z[COORD_BITS-1] && (req_ch.vec_z != '0);
      s1_flag_in.yaw_fix = 1'b1;
      priority if (y_zero) begin
         s1_flag_in.yaw_val = x_neg ? DEG_180 : DEG_0;
      end else if (x_zero) begin
         s1_flag_in.yaw_val = y_neg ? DEG_270 : DEG_90;
      end else if (ax == ay) begin
         if (!x_neg) begin
            s1_flag_in.yaw_val = y_neg ? DEG_315 : DEG_45;
         end else begin
            s1_flag_in.yaw_val = y_neg ? DEG_225 : DEG_135;
         end
      end else begin
         s1_flag_in.yaw_fix = 1'b0;
         s1_flag_in.yaw_val = DEG_0;
      end
   end

   assign s2_ready      = !s2_valid_ff || out_ready;
   assign req_ch.ready  = !s1_valid_ff || s2_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (req_ch.ready) begin
         s1_valid_ff <= req_ch.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_ch.ready && req_ch.valid) begin
         s1_cx_ff   <= s1_cx_in;
         s1_cy_ff   <= s1_cy_in;
         s1_ang_ff  <= s1_ang_in;
         s1_zy_ff   <= CW'(zy_prod);
         s1_sqx_ff  <= s1_sqx_in;
         s1_sqy_ff  <= s1_sqy_in;
         s1_sqz_ff  <= s1_sqz_in;
         s1_flag_ff <= s1_flag_in;
      end
   end

   // stage 2: exact pitch cases, then hand over to the rotation chain
   assign sq_sum   = {1'b0, s1_sqx_ff} + {1'b0, s1_sqy_ff};
   assign diag_hit = (sq_sum == {1'b0, s1_sqz_ff});

   always_comb begin
      s2_data_in.x              = s1_cx_ff;
      s2_data_in.y              = s1_cy_ff;
      s2_data_in.ang            = s1_ang_ff;
      s2_data_in.side.hold      = s1_zy_ff;
      s2_data_in.side.yaw_fix   = s1_flag_ff.zero_h || s1_flag_ff.yaw_fix;
      s2_data_in.side.yaw_val   = s1_flag_ff.zero_h ? DEG_0 : s1_flag_ff.yaw_val;
      s2_data_in.side.pitch_fix = 1'b1;
      priority if (s1_flag_ff.zero_h) begin
         s2_data_in.side.pitch_val = s1_flag_ff.z_pos ? DEG_90 : DEG_270;
      end else if (s1_flag_ff.z_zero) begin
         s2_data_in.side.pitch_val = DEG_0;
      end else if (diag_hit) begin
         s2_data_in.side.pitch_val = s1_flag_ff.z_pos ? DEG_45 : DEG_315;
      end else begin
         s2_data_in.side.pitch_fix = 1'b0;
         s2_data_in.side.pitch_val = DEG_0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else if (s2_ready) begin
         s2_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (s2_ready && s1_valid_ff) begin
         s2_data_ff <= s2_data_in;
      end
   end

   assign out_valid = s2_valid_ff;
   assign out_data  = s2_data_ff;

endmodule

`default_nettype wire

// ===== hdl/v2pyd_post.sv =====
`default_nettype none

module v2pyd_post import v2pyd_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         in_valid,
   output logic         in_ready,
   input  rot_type      in_data,
   v2pyd_rsp_if.source  rsp_ch
);

   // truncate toward zero to whole degrees, wrap negatives into 0..359
   function automatic logic [OUT_W-1:0] to_deg(input logic signed [ANG_W-1:0] ang);
      logic [ANG_W-1:0] mag;
      logic [DEG_W-1:0] whole;
      logic [DEG_W-1:0] wrap;
      mag   = ang[ANG_W-1] ? ANG_W'(-ang) : ANG_W'(ang);
      whole = mag[ANG_W-1:ANG_SHIFT];
      wrap  = DEG_FULL - whole;
      if (!ang[ANG_W-1]) begin
         return whole[OUT_W-1:0];
      end else if (whole == '0) begin
         return DEG_0;
      end else begin
         return wrap[OUT_W-1:0];
      end
   endfunction

   logic             valid_ff;
   logic [OUT_W-1:0] pitch_in;
   logic [OUT_W-1:0] pitch_ff;
   logic [OUT_W-1:0] yaw_in;
   logic [OUT_W-1:0] yaw_ff;

   assign pitch_in = in_data.side.pitch_fix ? in_data.side.pitch_val : to_deg(in_data.ang);
   assign yaw_in   = in_data.side.yaw_fix ? in_data.side.yaw_val
                                          : to_deg(in_data.side.hold[ANG_W-1:0]);

   assign in_ready = !valid_ff || rsp_ch.ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         pitch_ff <= pitch_in;
         yaw_ff   <= yaw_in;
      end
   end

   assign rsp_ch.valid     = valid_ff;
   assign rsp_ch.pitch_deg = pitch_ff;
   assign rsp_ch.yaw_deg   = yaw_ff;

endmodule

`default_nettype wire

// ===== dv/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;
   import v2pyd_pkg::*;

   localparam int PIPE_LATENCY = 2 * CORDIC_STEPS + 3;
   localparam int IDLE_LIMIT   = 20 * PIPE_LATENCY;
   localparam int RANDOM_ITEMS = 1925;
   localparam int BURST_FIRST  = 700;
   localparam int BURST_LAST   = 1000;
   localparam int DRAIN_ITEM   = 1300;

   localparam int LEG_A [5] = '{3, 5, 8, 7, 20};
   localparam int LEG_B [5] = '{4, 12, 15, 24, 21};
   localparam int HYPOT [5] = '{5, 13, 17, 25, 29};

   typedef logic signed [COORD_BITS-1:0] coord_type;

   typedef struct packed {
      logic [OUT_W-1:0] pitch;
      logic [OUT_W-1:0] yaw;
   } angle_pair_type;

   typedef struct {
      coord_type      x;
      coord_type      y;
      coord_type      z;
      bit             typed;
      angle_pair_type angles;
   } dir_row_type;

   typedef struct {
      coord_type      x;
      coord_type      y;
      coord_type      z;
      angle_pair_type angles;
   } pending_entry_type;

   logic clock;
   logic reset;

   v2pyd_req_if req_ch ();
   v2pyd_rsp_if rsp_ch ();

   vector_to_pitch_yaw_degrees_core DUT (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   longint            atan_tab [CORDIC_STEPS];
   longint            gain_k;
   pending_entry_type pending [$];
   dir_row_type       dir_rows [$];
   bit                burst;
   bit                row_typed;
   angle_pair_type    row_angles;
   int                errors;
   int                vectors_sent;
   int                results_checked;
   int                diag_items;
   int                pyth_items;
   int                idle_cycles;

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // arctangent table in 2^-32 degree and cordic gain in Q(FRAC_BITS)
   initial begin
      longint unsigned acc;
      longint unsigned term;
      longint unsigned k2;
      longint unsigned v;
      longint unsigned root;
      longint unsigned bitw;
      atan_tab[0] = longint'(45) <<< ANG_SHIFT;
      for (int i = 1; i < CORDIC_STEPS; i++) begin
         acc = 0;
         for (int k = 0; (2 * k + 1) * i <= 62; k++) begin
            term = (64'd1 << (62 - (2 * k + 1) * i)) / 64'(2 * k + 1);
            if (k % 2 == 1) begin
               acc -= term;
            end else begin
               acc += term;
            end
         end
         atan_tab[i] = longint'(((acc >> 30) * DEG_PER_RAD_Q26) >> 26);
      end
      k2 = 64'd1 << 61;
      for (int i = 1; i < CORDIC_STEPS; i++) begin
         k2 += k2 >> (2 * i);
      end
      v    = k2 >> (60 - 2 * FRAC_BITS);
      root = 0;
      bitw = 64'd1 << 62;
      while (bitw > v) bitw >>= 2;
      while (bitw != 0) begin
         if (v >= root + bitw) begin
            v    -= root + bitw;
            root = (root >> 1) + bitw;
         end else begin
            root >>= 1;
         end
         bitw >>= 2;
      end
      gain_k = longint'(root);
   end

   function automatic longint rotate_to_axis(inout longint mag, input longint y_in,
                                              input longint ang_in);
      longint xr;
      longint yr;
      longint ang;
      longint dx;
      longint dy;
      xr  = mag;
      yr  = y_in;
      ang = ang_in;
      for (int i = 0; i < CORDIC_STEPS; i++) begin
         dx = yr >>> i;
         dy = xr >>> i;
         if (yr >= 0) begin
            xr  += dx;
            yr  -= dy;
            ang += atan_tab[i];
         end else begin
            xr  -= dx;
            yr  += dy;
            ang -= atan_tab[i];
         end
      end
      mag = xr;
      return ang;
   endfunction

   // truncate toward zero, then wrap negatives
   function automatic logic [OUT_W-1:0] whole_degrees(input longint ang);
      longint t;
      if (ang < 0) begin
         t = -((-ang) >>> ANG_SHIFT);
      end else begin
         t = ang >>> ANG_SHIFT;
      end
      if (t < 0) t += longint'(DEG_FULL);
      return t[OUT_W-1:0];
   endfunction

   function automatic angle_pair_type predict_angles(input coord_type vx, input coord_type vy,
                                                     input coord_type vz);
      longint          x;
      longint          y;
      longint          z;
      longint          cx;
      longint          cy;
      longint          ang;
      longint unsigned ax;
      longint unsigned ay;
      longint unsigned az;
      angle_pair_type  r;
      x = vx;
      y = vy;
      z = vz;
      if (x == 0 && y == 0) begin
         r.pitch = (z > 0) ? DEG_90 : DEG_270;
         r.yaw   = DEG_0;
         return r;
      end
      cx  = x <<< FRAC_BITS;
      cy  = y <<< FRAC_BITS;
      ang = 0;
      if (x < 0) begin
         ang = longint'(180) <<< ANG_SHIFT;
         if (y < 0) ang = -ang;
         cx = -cx;
         cy = -cy;
      end
      ang = rotate_to_axis(cx, cy, ang);
      ax  = (x < 0) ? -x : x;
      ay  = (y < 0) ? -y : y;
      az  = (z < 0) ? -z : z;
      if (y == 0) begin
         r.yaw = (x > 0) ? DEG_0 : DEG_180;
      end else if (x == 0) begin
         r.yaw = (y > 0) ? DEG_90 : DEG_270;
      end else if (ax == ay) begin
         if (x > 0) begin
            r.yaw = (y > 0) ? DEG_45 : DEG_315;
         end else begin
            r.yaw = (y > 0) ? DEG_135 : DEG_225;
         end
      end else begin
         r.yaw = whole_degrees(ang);
      end
      if (z == 0) begin
         r.pitch = DEG_0;
      end else if (az * az == ax * ax + ay * ay) begin
         r.pitch = (z > 0) ? DEG_45 : DEG_315;
      end else begin
         r.pitch = whole_degrees(rotate_to_axis(cx, z * gain_k, 0));
      end
      return r;
   endfunction

   function automatic int draw_wait();
      return burst ? 0 : int'($urandom_range(0, 3));
   endfunction

   function automatic coord_type random_component();
      case ($urandom_range(0, 9))
         0: return '0;
         1: return $urandom_range(0, 1) ? 24'sh7FFFFF : 24'sh800000;
         2: return coord_type'($signed($urandom_range(0, 16)) - 8);
         3, 4, 5: return coord_type'($urandom());
         default: return coord_type'($signed($urandom()) >>> $urandom_range(0, 22));
      endcase
   endfunction

   task automatic report_mismatch(input string msg);
      errors++;
      if (errors <= 25) $display("%0t mismatch: %s", $time, msg);
   endtask

   task automatic send_vector(input coord_type vx, input coord_type vy, input coord_type vz,
                              input bit typed, input angle_pair_type angles);
      int gap;
      gap = draw_wait();
      if (gap > 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_ch.valid <= 1'b1;
      req_ch.vec_x <= vx;
      req_ch.vec_y <= vy;
      req_ch.vec_z <= vz;
      row_typed    <= typed;
      row_angles   <= angles;
      do @(posedge clock); while (!req_ch.ready);
      @(negedge clock);
   endtask

   // scoreboard
   always @(posedge clock) begin
      pending_entry_type want;
      if (!reset) begin
         if (req_ch.valid && req_ch.ready) begin
            want.x      = req_ch.vec_x;
            want.y      = req_ch.vec_y;
            want.z      = req_ch.vec_z;
            want.angles = row_typed ? row_angles
                                    : predict_angles(req_ch.vec_x, req_ch.vec_y, req_ch.vec_z);
            pending.push_back(want);
            vectors_sent++;
         end
         if (rsp_ch.valid && rsp_ch.ready) begin
            if (pending.size() == 0) begin
               report_mismatch($sformatf("result pitch %0d yaw %0d with no item pending",
                                         rsp_ch.pitch_deg, rsp_ch.yaw_deg));
            end else begin
               want = pending.pop_front();
               results_checked++;
               if (rsp_ch.pitch_deg !== want.angles.pitch) begin
                  report_mismatch($sformatf("(%0d,%0d,%0d) pitch got %0d want %0d",
                                            want.x, want.y, want.z,
                                            rsp_ch.pitch_deg, want.angles.pitch));
               end
               if (rsp_ch.yaw_deg !== want.angles.yaw) begin
                  report_mismatch($sformatf("(%0d,%0d,%0d) yaw got %0d want %0d",
                                            want.x, want.y, want.z,
                                            rsp_ch.yaw_deg, want.angles.yaw));
               end
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset) begin
         idle_cycles = 0;
      end else if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
         idle_cycles = 0;
      end else begin
         idle_cycles = idle_cycles + 1;
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("watchdog: no handshake for %0d cycles, %0d items pending",
                     idle_cycles, pending.size());
            $display("FAILURE");
            $finish;
         end
      end
   end

   // result side backpressure
   initial begin
      int w;
      rsp_ch.ready <= 1'b0;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         w = draw_wait();
         if (w > 0) begin
            rsp_ch.ready <= 1'b0;
            repeat (w) @(negedge clock);
         end
         rsp_ch.ready <= 1'b1;
         do @(posedge clock); while (!rsp_ch.valid);
         @(negedge clock);
      end
   end

   initial begin
      coord_type x;
      coord_type y;
      coord_type z;
      int        t;
      int        s;
      int        a;
      int        b;
      int        c;
      errors          = 0;
      vectors_sent    = 0;
      results_checked = 0;
      diag_items      = 0;
      pyth_items      = 0;
      burst           = 1'b0;
      reset        <= 1'b1;
      req_ch.valid <= 1'b0;
      req_ch.vec_x <= '0;
      req_ch.vec_y <= '0;
      req_ch.vec_z <= '0;
      row_typed    <= 1'b0;
      row_angles   <= '0;

      dir_rows.push_back('{24'sd0, 24'sd0, 24'sd1, 1'b1, '{DEG_90, DEG_0}});
      dir_rows.push_back('{24'sd0, 24'sd0, 24'sd0, 1'b1, '{DEG_270, DEG_0}});
      dir_rows.push_back('{24'sd0, 24'sd0, -24'sd1, 1'b1, '{DEG_270, DEG_0}});
      dir_rows.push_back('{24'sd0, 24'sd0, 24'sh7FFFFF, 1'b1, '{DEG_90, DEG_0}});
      dir_rows.push_back('{24'sd0, 24'sd0, 24'sh800000, 1'b1, '{DEG_270, DEG_0}});
      dir_rows.push_back('{24'sh7FFFFF, 24'sd0, 24'sd0, 1'b1, '{DEG_0, DEG_0}});
      dir_rows.push_back('{24'sh800000, 24'sd0, 24'sd0, 1'b1, '{DEG_0, DEG_180}});
      dir_rows.push_back('{24'sd0, 24'sh7FFFFF, 24'sd0, 1'b1, '{DEG_0, DEG_90}});
      dir_rows.push_back('{24'sd0, 24'sh800000, 24'sd0, 1'b1, '{DEG_0, DEG_270}});
      dir_rows.push_back('{24'sd5, 24'sd5, 24'sd0, 1'b1, '{DEG_0, DEG_45}});
      dir_rows.push_back('{-24'sd5, 24'sd5, 24'sd0, 1'b1, '{DEG_0, DEG_135}});
      dir_rows.push_back('{-24'sd5, -24'sd5, 24'sd0, 1'b1, '{DEG_0, DEG_225}});
      dir_rows.push_back('{24'sd5, -24'sd5, 24'sd0, 1'b1, '{DEG_0, DEG_315}});
      dir_rows.push_back('{24'sh800000, 24'sh800000, 24'sd0, 1'b1, '{DEG_0, DEG_225}});
      dir_rows.push_back('{24'sd3, 24'sd0, 24'sd3, 1'b1, '{DEG_45, DEG_0}});
      dir_rows.push_back('{24'sd0, -24'sd4, -24'sd4, 1'b1, '{DEG_315, DEG_270}});
      dir_rows.push_back('{-24'sd3, 24'sd4, 24'sd5, 1'b0, '0});
      dir_rows.push_back('{24'sh7FFFFF, 24'sh7FFFFF, 24'sh7FFFFF, 1'b0, '0});
      dir_rows.push_back('{24'sh800000, 24'sh800000, 24'sh800000, 1'b0, '0});
      dir_rows.push_back('{24'sh800000, 24'sd1, 24'sd0, 1'b0, '0});
      dir_rows.push_back('{24'sh800000, -24'sd1, 24'sd0, 1'b0, '0});
      dir_rows.push_back('{24'sh7FFFFF, 24'sh800000, 24'sd1, 1'b0, '0});
      dir_rows.push_back('{24'sd1, 24'sd1, 24'sh800000, 1'b0, '0});
      dir_rows.push_back('{-24'sd1, -24'sd2, 24'sd3, 1'b0, '0});
      dir_rows.push_back('{24'sd2, 24'sd1, -24'sh7FFFFF, 1'b0, '0});

      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (dir_rows[i]) begin
         send_vector(dir_rows[i].x, dir_rows[i].y, dir_rows[i].z,
                     dir_rows[i].typed, dir_rows[i].angles);
      end

      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         burst = (n >= BURST_FIRST && n < BURST_LAST);
         if (n == DRAIN_ITEM) begin
            req_ch.valid <= 1'b0;
            @(negedge clock);
            while (pending.size() != 0) @(negedge clock);
         end
         x = random_component();
         y = random_component();
         z = random_component();
         case ($urandom_range(0, 9))
            0: begin
               y = $urandom_range(0, 1) ? x : -x;
               diag_items++;
            end
            1: begin
               t = $urandom_range(0, 4);
               s = $urandom_range(1, 280000);
               a = $urandom_range(0, 1) ? LEG_A[t] * s : -LEG_A[t] * s;
               b = $urandom_range(0, 1) ? LEG_B[t] * s : -LEG_B[t] * s;
               c = $urandom_range(0, 1) ? HYPOT[t] * s : -HYPOT[t] * s;
               x = coord_type'($urandom_range(0, 1) ? a : b);
               y = coord_type'((x == coord_type'(a)) ? b : a);
               z = coord_type'(c);
               pyth_items++;
            end
            2: begin
               if ($urandom_range(0, 1)) begin
                  y = '0;
               end else begin
                  y = x;
                  x = '0;
               end
               z = $urandom_range(0, 1) ? (x | y) : -(x | y);
               pyth_items++;
            end
            default: ;
         endcase
         send_vector(x, y, z, 1'b0, '0);
      end
      burst = 1'b0;
      req_ch.valid <= 1'b0;

      while (pending.size() != 0) @(posedge clock);
      repeat (PIPE_LATENCY + 10) @(posedge clock);

      $display("%0d vectors in (%0d directed, %0d on a diagonal, %0d with exact pitch setups)",
               vectors_sent, dir_rows.size(), diag_items, pyth_items);
      $display("%0d angle pairs compared, %0d mismatches", results_checked, errors);
      if (errors == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule
